[src/pip_pkg.sv]
// Shared types and constants for the point-in-polygon-with-margin block.
// Used by the front queue, the sequencer, the multiplier and the top level.
package pip_pkg;

  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int MARGIN_W     = 24;
  localparam int M2_W         = 2 * MARGIN_W;
  localparam int DIG_W        = 24;
  localparam int NDIG         = 3;
  localparam int OPD_W        = DIG_W * NDIG;
  localparam int PROD_W       = 2 * OPD_W;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [COORD_W-1:0]  east;
    logic signed [COORD_W-1:0]  north;
  } item_t;

  typedef struct packed {
    logic inside_res;
    logic by_margin;
    logic degenerate;
    logic overflowed;
  } res_t;

  typedef struct packed {
    logic                      start;
    logic signed [OPD_W-1:0]   a;
    logic signed [OPD_W-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [PROD_W-1:0]  p;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDJ,
    ST_LDJ,
    ST_RDI,
    ST_LDI,
    ST_MS,
    ST_MW,
    ST_NEXT,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    MS_RUN0,
    MS_RUN1,
    MS_T0,
    MS_T1,
    MS_DA0,
    MS_DA1,
    MS_END0,
    MS_END1,
    MS_MID0,
    MS_MID1,
    MS_XA,
    MS_XB
  } mstep_t;

endpackage

[src/pip_front.sv]
// Input side: accepts beats, drops unused op codes and queues the rest.
// Depends on pip_pkg for the queued item type.
module pip_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // east[31:0], north[63:32]
  input  logic [1:0]           in_tuser,   // op[1:0]
  output logic                 q_valid,
  output pip_pkg::item_t       q_item,
  input  logic                 q_pop
);

  pip_pkg::item_t                q_mem_r [pip_pkg::QDEPTH];
  logic [pip_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [pip_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [pip_pkg::QPTR_W:0]      fill_r, fill_nxt;
  logic                          push;
  logic                          pop;
  pip_pkg::item_t                in_item;

  assign in_item.op    = in_tuser;
  assign in_item.east  = in_tdata[31:0];
  assign in_item.north = in_tdata[63:32];

  assign in_tready = (fill_r != (pip_pkg::QPTR_W+1)'(pip_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready && (in_tuser != pip_pkg::OP_NONE);
  assign q_valid   = (fill_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (pip_pkg::QPTR_W+1)'(push) - (pip_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

[src/pip_mul.sv]
// Iterative signed multiplier: 24-bit digits, one partial product per cycle.
// Depends on pip_pkg for operand widths and the request/response types.
module pip_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  pip_pkg::mul_req_t   req,
  output pip_pkg::mul_rsp_t   rsp
);

  logic [pip_pkg::OPD_W-1:0]   ua_r, ub_r;
  logic                        neg_r;
  logic [1:0]                  ia_r, ib_r;
  logic [pip_pkg::PROD_W-1:0]  acc_r;
  logic                        busy_r, fin_r, done_r;
  logic signed [pip_pkg::PROD_W-1:0] p_r;
  logic [pip_pkg::DIG_W-1:0]   da, db;
  logic [2*pip_pkg::DIG_W-1:0] pp;
  logic [2:0]                  dsum;
  logic [7:0]                  sh;
  logic [pip_pkg::PROD_W-1:0]  pp_sh;

  assign da    = ua_r[ia_r * pip_pkg::DIG_W +: pip_pkg::DIG_W];
  assign db    = ub_r[ib_r * pip_pkg::DIG_W +: pip_pkg::DIG_W];
  assign pp    = da * db;
  assign dsum  = {1'b0, ia_r} + {1'b0, ib_r};
  assign sh    = {1'b0, dsum, 4'b0} + {2'b0, dsum, 3'b0};
  assign pp_sh = {{(pip_pkg::PROD_W - 2*pip_pkg::DIG_W){1'b0}}, pp} << sh;

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && ib_r == 2'd2 && ia_r == 2'd2) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      ua_r  <= req.a[pip_pkg::OPD_W-1] ? pip_pkg::OPD_W'(-req.a) : req.a;
      ub_r  <= req.b[pip_pkg::OPD_W-1] ? pip_pkg::OPD_W'(-req.b) : req.b;
      neg_r <= req.a[pip_pkg::OPD_W-1] ^ req.b[pip_pkg::OPD_W-1];
      ia_r  <= '0;
      ib_r  <= '0;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
      if (ib_r == 2'd2) begin
        ib_r <= '0;
        ia_r <= ia_r + 1'b1;
      end else begin
        ib_r <= ib_r + 1'b1;
      end
    end
    if (fin_r) begin
      p_r <= neg_r ? -signed'(acc_r) : signed'(acc_r);
    end
  end

endmodule

[src/pip_back.sv]
// Back end: vertex store, edge walk sequencer and result register.
// Depends on pip_pkg; drives the shared multiplier pip_mul.
module pip_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pip_pkg::MARGIN_W-1:0]   cfg_wdata,
  input  logic                           q_valid,
  input  pip_pkg::item_t                 q_item,
  output logic                           q_pop,
  output pip_pkg::mul_req_t              mul_req,
  input  pip_pkg::mul_rsp_t              mul_rsp,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,
  output logic [2:0]                     out_tuser
);

  localparam int CW = pip_pkg::COORD_W;
  localparam int DW = pip_pkg::DIFF_W;
  localparam int OW = pip_pkg::OPD_W;
  localparam int PW = pip_pkg::PROD_W;

  pip_pkg::state_t state_r, state_nxt;
  pip_pkg::mstep_t step_r, step_nxt;
  logic [pip_pkg::MARGIN_W-1:0] margin_r, margin_nxt;
  logic [pip_pkg::M2_W-1:0]     m2_r, m2_nxt;
  logic [pip_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [pip_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                         pass_r, pass_nxt;
  logic                         inside_r, inside_nxt;
  logic signed [CW-1:0]         px_r, px_nxt, py_r, py_nxt;
  logic signed [CW-1:0]         xi_r, xi_nxt, yi_r, yi_nxt;
  logic signed [CW-1:0]         xj_r, xj_nxt, yj_r, yj_nxt;
  logic signed [OW-1:0]         run_r, run_nxt, t_r, t_nxt, da_r, da_nxt;
  logic signed [PW-1:0]         q_r, q_nxt;
  pip_pkg::res_t                res_r, res_nxt;
  pip_pkg::res_t                ores_r, ores_nxt;
  logic                         ovalid_r, ovalid_nxt;

  logic [CW-1:0] mem_e [pip_pkg::MAX_VERTICES];
  logic [CW-1:0] mem_n [pip_pkg::MAX_VERTICES];
  logic signed [CW-1:0] rd_e_r, rd_n_r;
  logic                      we;
  logic [pip_pkg::IDX_W-1:0] wa;

  logic [pip_pkg::IDX_W-1:0] last;
  logic signed [DW-1:0] ex, ey, dx, dy, fx, fy;
  logic signed [OW-1:0] da_tot;
  logic signed [PW-1:0] m2_w, p;
  logic                 near;
  logic                 si;
  logic                 sj;

  function automatic logic signed [OW-1:0] ext(input logic signed [DW-1:0] v);
    return {{(OW - DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

  assign last   = pip_pkg::IDX_W'(cnt_r - 1'b1);
  assign ex     = dif(xj_r, xi_r);
  assign ey     = dif(yj_r, yi_r);
  assign dx     = dif(px_r, xi_r);
  assign dy     = dif(py_r, yi_r);
  assign fx     = dif(px_r, xj_r);
  assign fy     = dif(py_r, yj_r);
  assign p      = mul_rsp.p;
  assign m2_w   = signed'({{(PW - pip_pkg::M2_W){1'b0}}, m2_r});
  assign da_tot = da_r + signed'(p[OW-1:0]);
  assign si     = rd_n_r > py_r;
  assign sj     = yj_r > py_r;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'b0, ores_r.inside_res};
  assign out_tuser  = {ores_r.overflowed, ores_r.degenerate, ores_r.by_margin};

  always_comb begin
    mul_req.start = (state_r == pip_pkg::ST_MS);
    mul_req.a     = ext(ex);
    mul_req.b     = ext(ex);
    case (step_r)
      pip_pkg::MS_RUN1: begin mul_req.a = ext(ey); mul_req.b = ext(ey); end
      pip_pkg::MS_T0:   begin mul_req.a = ext(dx); mul_req.b = ext(ex); end
      pip_pkg::MS_T1:   begin mul_req.a = ext(dy); mul_req.b = ext(ey); end
      pip_pkg::MS_DA0:  begin mul_req.a = ext(dx); mul_req.b = ext(dx); end
      pip_pkg::MS_DA1:  begin mul_req.a = ext(dy); mul_req.b = ext(dy); end
      pip_pkg::MS_END0: begin mul_req.a = ext(fx); mul_req.b = ext(fx); end
      pip_pkg::MS_END1: begin mul_req.a = ext(fy); mul_req.b = ext(fy); end
      pip_pkg::MS_MID0: begin
        mul_req.a = da_r - signed'({{(OW - pip_pkg::M2_W){1'b0}}, m2_r});
        mul_req.b = run_r;
      end
      pip_pkg::MS_MID1: begin mul_req.a = t_r; mul_req.b = t_r; end
      pip_pkg::MS_XA:   begin mul_req.a = ext(dx); mul_req.b = ext(ey); end
      pip_pkg::MS_XB:   begin mul_req.a = ext(ex); mul_req.b = ext(dy); end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    margin_nxt = cfg_we ? cfg_wdata : margin_r;
    m2_nxt     = m2_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    pass_nxt   = pass_r;
    inside_nxt = inside_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    xi_nxt     = xi_r;
    yi_nxt     = yi_r;
    xj_nxt     = xj_r;
    yj_nxt     = yj_r;
    run_nxt    = run_r;
    t_nxt      = t_r;
    da_nxt     = da_r;
    q_nxt      = q_r;
    res_nxt    = res_r;
    ores_nxt   = ores_r;
    ovalid_nxt = ovalid_r && !out_tready;
    q_pop      = 1'b0;
    we         = 1'b0;
    wa         = cnt_r[pip_pkg::IDX_W-1:0];
    near       = 1'b0;
    unique case (state_r)
      pip_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == pip_pkg::OP_QUERY) begin
            px_nxt     = q_item.east;
            py_nxt     = q_item.north;
            m2_nxt     = {{pip_pkg::MARGIN_W{1'b0}}, margin_r}
                         * {{pip_pkg::MARGIN_W{1'b0}}, margin_r};
            inside_nxt = 1'b0;
            pass_nxt   = 1'b0;
            idx_nxt    = last;
            res_nxt    = '{inside_res: 1'b1, by_margin: 1'b0, degenerate: 1'b1,
                           overflowed: ovf_r};
            if (cnt_r < pip_pkg::CNT_W'(3)) begin
              state_nxt = pip_pkg::ST_EMIT;
            end else begin
              state_nxt = pip_pkg::ST_RDJ;
            end
          end else begin
            if (q_item.op == pip_pkg::OP_START) begin
              we      = 1'b1;
              wa      = '0;
              cnt_nxt = pip_pkg::CNT_W'(1);
              ovf_nxt = 1'b0;
            end else if (cnt_r == pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES)) begin
              ovf_nxt = 1'b1;
            end else begin
              we      = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      pip_pkg::ST_RDJ: state_nxt = pip_pkg::ST_LDJ;
      pip_pkg::ST_LDJ: begin
        xj_nxt    = rd_e_r;
        yj_nxt    = rd_n_r;
        idx_nxt   = '0;
        state_nxt = pip_pkg::ST_RDI;
      end
      pip_pkg::ST_RDI: state_nxt = pip_pkg::ST_LDI;
      pip_pkg::ST_LDI: begin
        xi_nxt = rd_e_r;
        yi_nxt = rd_n_r;
        if (pass_r) begin
          step_nxt  = pip_pkg::MS_RUN0;
          state_nxt = pip_pkg::ST_MS;
        end else if (si != sj) begin
          step_nxt  = pip_pkg::MS_XA;
          state_nxt = pip_pkg::ST_MS;
        end else begin
          state_nxt = pip_pkg::ST_NEXT;
        end
      end
      pip_pkg::ST_MS: state_nxt = pip_pkg::ST_MW;
      pip_pkg::ST_MW: begin
        if (mul_rsp.done) begin
          state_nxt = pip_pkg::ST_MS;
          case (step_r)
            pip_pkg::MS_RUN0: begin
              run_nxt = signed'(p[OW-1:0]); step_nxt = pip_pkg::MS_RUN1;
            end
            pip_pkg::MS_RUN1: begin
              run_nxt = run_r + signed'(p[OW-1:0]); step_nxt = pip_pkg::MS_T0;
            end
            pip_pkg::MS_T0: begin
              t_nxt = signed'(p[OW-1:0]); step_nxt = pip_pkg::MS_T1;
            end
            pip_pkg::MS_T1: begin
              t_nxt = t_r + signed'(p[OW-1:0]); step_nxt = pip_pkg::MS_DA0;
            end
            pip_pkg::MS_DA0: begin
              da_nxt = signed'(p[OW-1:0]); step_nxt = pip_pkg::MS_DA1;
            end
            pip_pkg::MS_DA1: begin
              da_nxt = da_tot;
              if (run_r == '0 || t_r <= 0) begin
                near      = signed'({{(PW - OW){da_tot[OW-1]}}, da_tot}) <= m2_w;
                state_nxt = pip_pkg::ST_NEXT;
              end else if (t_r >= run_r) begin
                step_nxt = pip_pkg::MS_END0;
              end else begin
                step_nxt = pip_pkg::MS_MID0;
              end
            end
            pip_pkg::MS_END0: begin
              q_nxt = p; step_nxt = pip_pkg::MS_END1;
            end
            pip_pkg::MS_END1: begin
              near      = (q_r + p) <= m2_w;
              state_nxt = pip_pkg::ST_NEXT;
            end
            pip_pkg::MS_MID0: begin
              q_nxt = p; step_nxt = pip_pkg::MS_MID1;
            end
            pip_pkg::MS_MID1: begin
              near      = q_r <= p;
              state_nxt = pip_pkg::ST_NEXT;
            end
            pip_pkg::MS_XA: begin
              q_nxt = p; step_nxt = pip_pkg::MS_XB;
            end
            pip_pkg::MS_XB: begin
              if (ey[DW-1] ? (q_r > p) : (q_r < p)) begin
                inside_nxt = !inside_r;
              end
              state_nxt = pip_pkg::ST_NEXT;
            end
            default: state_nxt = pip_pkg::ST_NEXT;
          endcase
          if (near) begin
            res_nxt   = '{inside_res: 1'b1, by_margin: 1'b1, degenerate: 1'b0,
                          overflowed: ovf_r};
            state_nxt = pip_pkg::ST_EMIT;
          end
        end
      end
      pip_pkg::ST_NEXT: begin
        xj_nxt = xi_r;
        yj_nxt = yi_r;
        if (idx_r == last) begin
          if (!pass_r && inside_r) begin
            res_nxt   = '{inside_res: 1'b1, by_margin: 1'b0, degenerate: 1'b0,
                          overflowed: ovf_r};
            state_nxt = pip_pkg::ST_EMIT;
          end else if (!pass_r) begin
            pass_nxt  = 1'b1;
            idx_nxt   = last;
            state_nxt = pip_pkg::ST_RDJ;
          end else begin
            res_nxt   = '{inside_res: 1'b0, by_margin: 1'b0, degenerate: 1'b0,
                          overflowed: ovf_r};
            state_nxt = pip_pkg::ST_EMIT;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = pip_pkg::ST_RDI;
        end
      end
      pip_pkg::ST_EMIT: begin
        if (!ovalid_r || out_tready) begin
          ores_nxt   = res_r;
          ovalid_nxt = 1'b1;
          state_nxt  = pip_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pip_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pip_pkg::ST_IDLE;
      margin_r <= '0;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      margin_r <= margin_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    m2_r     <= m2_nxt;
    idx_r    <= idx_nxt;
    pass_r   <= pass_nxt;
    inside_r <= inside_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    xi_r     <= xi_nxt;
    yi_r     <= yi_nxt;
    xj_r     <= xj_nxt;
    yj_r     <= yj_nxt;
    run_r    <= run_nxt;
    t_r      <= t_nxt;
    da_r     <= da_nxt;
    q_r      <= q_nxt;
    res_r    <= res_nxt;
    ores_r   <= ores_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_e[wa] <= q_item.east;
      mem_n[wa] <= q_item.north;
    end
    rd_e_r <= mem_e[idx_r];
    rd_n_r <= mem_n[idx_r];
  end

endmodule

[src/point_in_polygon_with_margin.sv]
// Top level of the point-in-polygon test with distance margin.
// Depends on pip_pkg, pip_front, pip_mul and pip_back.
//
// Usage: in_* carries one beat per command, op in in_tuser (0 append vertex,
// 1 start new ring with this vertex, 2 query point, 3 ignored) and the east
// and north coordinates in in_tdata. out_* carries one beat per query with
// inside_res in out_tdata and by_margin, degenerate, overflowed in out_tuser.
// cfg_we/cfg_wdata load the margin; write it only while the block is idle.
// A four-beat queue sits between the input and the sequencer, so commands
// keep being accepted while a query is worked on or a result waits.
// A vertex command is taken from the queue while the sequencer is idle.
// A query on a ring of n vertices runs a crossing pass with up to 2
// multiplies per edge and, unless the point is found inside, a margin
// pass with 6 to 8 multiplies per edge, all on the single shared iterative
// multiplier. A ring of fewer than three vertices answers without either
// pass. Reset empties the ring and the queue,
// clears the overflow flag and sets the margin to zero. When the receiver
// stalls, the result holds in the output register; the next query finishes
// its work and then waits, while the queue keeps filling.
module point_in_polygon_with_margin (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // east[31:0], north[63:32]
  input  logic [1:0]  in_tuser,    // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // inside_res[0], zero pad [7:1]
  output logic [2:0]  out_tuser,   // by_margin[0], degenerate[1], overflowed[2]
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  logic               q_valid;
  logic               q_pop;
  pip_pkg::item_t     q_item;
  pip_pkg::mul_req_t  mul_req;
  pip_pkg::mul_rsp_t  mul_rsp;

  pip_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  pip_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  pip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[tb/sv/testbench.sv]
// Testbench for point_in_polygon_with_margin: directed table, then random rings and queries.
// Depends on pip_pkg and the block's RTL; expected verdicts come from a 256-bit exact predictor.
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [1:0]    op;
    logic [31:0]   east;
    logic [31:0]   north;
    bit            typed;
    pip_pkg::res_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = pip_pkg::OP_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;

  logic signed [31:0] ring_east [pip_pkg::MAX_VERTICES];
  logic signed [31:0] ring_north [pip_pkg::MAX_VERTICES];
  int                 ring_count;
  bit                 ring_ovf;
  logic [23:0]        margin_reg;

  pip_pkg::res_t verdicts [$];
  int            mismatches;
  int            idle_cycles;
  int            ready_hold;
  bit            no_idle;
  bit            pend_typed;
  pip_pkg::res_t pend_want;

  point_in_polygon_with_margin DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic pip_pkg::res_t verdict(input logic signed [31:0] qe,
                                            input logic signed [31:0] qn);
    logic signed [255:0] px, py, xi, yi, xj, yj, d, lhs, rhs, ex, ey, run, dx, dy, t, da, m2;
    bit            odd, near;
    int            j;
    pip_pkg::res_t r;
    r.overflowed = ring_ovf;
    if (ring_count < 3) begin
      r.inside_res = 1; r.by_margin = 0; r.degenerate = 1;
      return r;
    end
    r.degenerate = 0;
    px = qe;
    py = qn;
    odd = 0;
    j = ring_count - 1;
    for (int i = 0; i < ring_count; i++) begin
      yi = ring_north[i]; yj = ring_north[j];
      if ((yi > py) != (yj > py)) begin
        xi = ring_east[i]; xj = ring_east[j];
        d = yj - yi;
        lhs = (px - xi) * d;
        rhs = (xj - xi) * (py - yi);
        if (d < 0 ? lhs > rhs : lhs < rhs) odd = !odd;
      end
      j = i;
    end
    if (odd) begin
      r.inside_res = 1; r.by_margin = 0;
      return r;
    end
    m2 = $signed({232'd0, margin_reg}) * $signed({232'd0, margin_reg});
    near = 0;
    j = ring_count - 1;
    for (int i = 0; i < ring_count && !near; i++) begin
      xi = ring_east[i]; xj = ring_east[j];
      yi = ring_north[i]; yj = ring_north[j];
      ex = xj - xi; ey = yj - yi;
      run = ex * ex + ey * ey;
      dx = px - xi; dy = py - yi;
      t = dx * ex + dy * ey;
      da = dx * dx + dy * dy;
      if (run == 0 || !(t > 0)) near = da <= m2;
      else if (t >= run) near = (px - xj) * (px - xj) + (py - yj) * (py - yj) <= m2;
      else near = (da - m2) * run <= t * t;
      j = i;
    end
    r.inside_res = near; r.by_margin = near;
    return r;
  endfunction

  task automatic absorb(input logic [1:0] op, input logic [31:0] e, input logic [31:0] n);
    pip_pkg::res_t r;
    if (op == pip_pkg::OP_APPEND || op == pip_pkg::OP_START) begin
      if (op == pip_pkg::OP_START) begin
        ring_count = 0; ring_ovf = 0;
      end
      if (ring_count < pip_pkg::MAX_VERTICES) begin
        ring_east[ring_count] = e; ring_north[ring_count] = n; ring_count++;
      end else ring_ovf = 1;
    end else if (op == pip_pkg::OP_QUERY) begin
      r = verdict(e, n);
      if (pend_typed) r = pend_want;
      verdicts = {verdicts, r};
    end
  endtask

  task automatic send(input logic [1:0] op, input logic [31:0] e, input logic [31:0] n);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {n, e};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb(op, e, n);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_margin(input logic [23:0] m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    margin_reg = m;
  endtask

  function automatic logic [31:0] near_coord(input longint c, input longint r);
    longint v;
    v = c + longint'($urandom_range(0, 2 * r)) - r;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // beat monitor and result check
  always @(posedge clk) begin
    pip_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts.size() == 0) report("unexpected result", out_tdata[0], 0);
      else begin
        want = verdicts.pop_front();
        if (out_tdata[0] !== want.inside_res)
          report("inside_res", out_tdata[0], want.inside_res);
        if (out_tuser[0] !== want.by_margin) report("by_margin", out_tuser[0], want.by_margin);
        if (out_tuser[1] !== want.degenerate) report("degenerate", out_tuser[1], want.degenerate);
        if (out_tuser[2] !== want.overflowed) report("overflowed", out_tuser[2], want.overflowed);
        if (out_tdata[7:1] !== 7'd0) report("out_tdata pad", out_tdata[7:1], 0);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    int hold;
    hold = ready_hold;
    if (out_tvalid && out_tready) hold = no_idle ? 0 : $urandom_range(0, 10);
    else if (hold > 0) hold--;
    ready_hold <= hold;
    out_tready <= rst_n && hold == 0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else if (in_tvalid || verdicts.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    row_t table_rows [$];
    logic [23:0] margins [6];
    int   n, nq, sent;
    longint cx, cy, rad;
    logic [1:0] op;
    logic [31:0] e, nn;

    mismatches = 0; idle_cycles = 0; ready_hold = 0; no_idle = 0;
    pend_typed = 0; ring_count = 0; ring_ovf = 0; margin_reg = '0;

    table_rows = '{
      '{pip_pkg::OP_QUERY,  32'h0,        32'h0,        1, '{1'b1, 1'b0, 1'b1, 1'b0}},
      '{pip_pkg::OP_NONE,   32'h1234,     32'h5678,     0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_APPEND, 32'h0,        32'h0,        0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_APPEND, 32'h1000,     32'h0,        0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'h7FFFFFFF, 32'h80000000, 1, '{1'b1, 1'b0, 1'b1, 1'b0}},
      '{pip_pkg::OP_APPEND, 32'h0,        32'h1000,     0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'h100,      32'h100,      0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'h7FFFFFFF, 32'h7FFFFFFF, 0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'h80000000, 32'h80000000, 0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'h0,        32'h0,        0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'h800,      32'h800,      0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'hFFFFFF00, 32'h10,       0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_START,  32'h0,        32'h0,        0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_APPEND, 32'h0,        32'h0,        0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_APPEND, 32'h2000,     32'h2000,     0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'hFFFFFFF0, 32'h0,        0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'hFFFFFB00, 32'hFFFFFB00, 0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_START,  32'h7FFFFFFF, 32'h7FFFFFFF, 0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_APPEND, 32'h80000000, 32'h7FFFFFFF, 0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_APPEND, 32'h0,        32'h80000000, 0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'h0,        32'h0,        0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'h80000000, 32'h80000000, 0, '{0, 0, 0, 0}},
      '{pip_pkg::OP_QUERY,  32'h7FFFFFFF, 32'h0,        0, '{0, 0, 0, 0}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_margin(24'h000400);

    foreach (table_rows[k]) begin
      pend_typed = table_rows[k].typed;
      pend_want  = table_rows[k].want;
      send(table_rows[k].op, table_rows[k].east, table_rows[k].north);
    end
    pend_typed = 0;
    drain();

    margins = '{24'h000000, 24'hFFFFFF, 24'h000100, 24'h000001, 24'h0, 24'h0};
    margins[4] = 24'($urandom_range(0, 24'hFFFFFF));
    margins[5] = 24'($urandom_range(0, 24'h00FFFF));

    foreach (margins[p]) begin
      set_margin(margins[p]);
      sent = 0;
      while (sent < 80) begin
        no_idle = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 9))
          0:       n = $urandom_range(0, 2);
          1:       n = $urandom_range(60, 68);
          default: n = $urandom_range(3, 8);
        endcase
        if ($urandom_range(0, 4) == 0) begin
          cx = 0; cy = 0; rad = longint'(1) << $urandom_range(20, 30);
        end else begin
          rad = longint'(1) << $urandom_range(8, 16);
          cx = $signed($urandom()) >>> 2; cy = $signed($urandom()) >>> 2;
        end
        for (int v = 0; v < n; v++) begin
          op = (v == 0 && $urandom_range(0, 7) != 0) ? pip_pkg::OP_START : pip_pkg::OP_APPEND;
          send(op, near_coord(cx, rad), near_coord(cy, rad));
          sent++;
        end
        nq = $urandom_range(2, 8);
        for (int q = 0; q < nq; q++) begin
          case ($urandom_range(0, 9))
            0: begin e = $urandom(); nn = $urandom(); end
            1: begin
              e = (ring_count > 0) ? ring_east[0] : 32'h0;
              nn = (ring_count > 0) ? ring_north[0] : 32'h0;
            end
            default: begin
              e = near_coord(cx, rad + rad / 2); nn = near_coord(cy, rad + rad / 2);
            end
          endcase
          send(pip_pkg::OP_QUERY, e, nn);
          sent++;
          if ($urandom_range(0, 15) == 0) send(pip_pkg::OP_NONE, $urandom(), $urandom());
        end
        if (p == 2 && sent > 40 && sent < 50) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (verdicts.size() != 0) @(posedge clk);
        end
      end
      no_idle = 0;
      drain();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
